>>> rtl/dov_pkg.sv
package dov_pkg;

    // Default build-time sizes.
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SAMPLE_BITS_DEF     = 24;

    // Configuration port.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETUNE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 2'd3;

    // Envelopes are Q0.16 with one extra bit so that 1.0 is representable.
    localparam int            ENV_W   = 17;
    localparam int            DET_W   = 16;
    localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

    // Sine samples are Q1.15; the squares swing by one half.
    localparam int                     SINE_W    = 16;
    localparam logic signed [SINE_W-1:0] HALF_Q15 = 16'sd16384;

    // Table generator constants (Q30).
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Microcode step addresses.
    localparam int UC_W = 4;
    localparam logic [UC_W-1:0] UC_ACCEPT  = 4'd0;
    localparam logic [UC_W-1:0] UC_SINE    = 4'd1;
    localparam logic [UC_W-1:0] UC_UPPER   = 4'd2;
    localparam logic [UC_W-1:0] UC_LOWER   = 4'd3;
    localparam logic [UC_W-1:0] UC_MIX     = 4'd4;
    localparam logic [UC_W-1:0] UC_LEFT    = 4'd5;
    localparam logic [UC_W-1:0] UC_RIGHT   = 4'd6;
    localparam logic [UC_W-1:0] UC_SCALE_L = 4'd7;
    localparam logic [UC_W-1:0] UC_SCALE_R = 4'd8;
    localparam logic [UC_W-1:0] UC_DELIVER = 4'd9;

    // Condition a step waits on before it acts and moves on.
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    // Phase accumulator that addresses the sine ROM.
    typedef enum logic [1:0] {
        ADDR_MAIN,
        ADDR_UPPER,
        ADDR_LOWER
    } addr_sel_t;

    // Operand pair of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_DETUNE,
        MUL_ENV,
        MUL_LEFT,
        MUL_RIGHT,
        MUL_RECIP_L,
        MUL_RECIP_R
    } mul_sel_t;

    // One microcode control word.
    typedef struct packed {
        hold_t           hold;
        logic            jump;
        logic [UC_W-1:0] target;
        addr_sel_t       addr_sel;
        mul_sel_t        mul_sel;
        logic            ld_in;
        logic            ld_sine;
        logic            ld_upper;
        logic            ld_lower;
        logic            upd_env;
        logic            upd_phase;
        logic            ld_env;
        logic            ld_mix;
        logic            ld_q_l;
        logic            ld_q_r;
        logic            ld_res_l;
        logic            ld_out;
    } ctrl_t;

    // Microcode program, one control word per step.
    function automatic ctrl_t ucode(input logic [UC_W-1:0] pc);
        ctrl_t c;
        c = '0;
        unique case (pc)
            UC_ACCEPT:
            begin
                c.hold     = HOLD_IN;
                c.ld_in    = 1'b1;
                c.addr_sel = ADDR_MAIN;
                c.mul_sel  = MUL_DETUNE;
            end
            UC_SINE:
            begin
                c.ld_sine  = 1'b1;
                c.upd_env  = 1'b1;
                c.addr_sel = ADDR_UPPER;
                c.mul_sel  = MUL_DETUNE;
            end
            UC_UPPER:
            begin
                c.ld_upper  = 1'b1;
                c.upd_phase = 1'b1;
                c.addr_sel  = ADDR_LOWER;
                c.mul_sel   = MUL_ENV;
            end
            UC_LOWER:
            begin
                c.ld_lower = 1'b1;
                c.ld_env   = 1'b1;
                c.mul_sel  = MUL_ENV;
            end
            UC_MIX:
            begin
                c.ld_mix  = 1'b1;
                c.mul_sel = MUL_LEFT;
            end
            UC_LEFT:
            begin
                c.mul_sel = MUL_LEFT;
            end
            UC_RIGHT:
            begin
                c.ld_q_l  = 1'b1;
                c.mul_sel = MUL_RIGHT;
            end
            UC_SCALE_L:
            begin
                c.ld_q_r  = 1'b1;
                c.mul_sel = MUL_RECIP_L;
            end
            UC_SCALE_R:
            begin
                c.ld_res_l = 1'b1;
                c.mul_sel  = MUL_RECIP_R;
            end
            UC_DELIVER:
            begin
                c.hold    = HOLD_OUT;
                c.ld_out  = 1'b1;
                c.mul_sel = MUL_RECIP_R;
                c.jump    = 1'b1;
                c.target  = UC_ACCEPT;
            end
            default:
            begin
                c.jump   = 1'b1;
                c.target = UC_ACCEPT;
            end
        endcase
        return c;
    endfunction

    // Quarter-wave sine sample in Q1.15 from a Q30 Taylor series up to x^11.
    function automatic logic signed [SINE_W-1:0] quarter_sine(input logic [31:0] q,
                                                              input int tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = ((64'd2 * PI_Q30) * 64'(q)) >> tbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        return SINE_W'((s * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

endpackage

>>> rtl/detuned_oscillator_voice.sv
// Channel   Handshake                 Payload
// input     in_valid / in_stall       in_left, in_right, release_now
// output    out_valid / out_stall     out_left, out_right, voice_dead
// config    cfg_we                    cfg_index, cfg_data
//
// One sample runs through the microcode program from its input transfer to
// its result: three reads of the single-port sine ROM and six products
// through the one shared multiplier. No new sample is taken before the
// program is back on its accept step; the input stalls on every other step.
// A finished result waits in the output register, and the next sample is
// taken meanwhile; the sequencer only halts on its last step while that
// register is still full. Reset sets all but the datapath registers at once.
module detuned_oscillator_voice
    import dov_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] in_left,
    input  logic signed [SAMPLE_BITS-1:0] in_right,
    input  logic                          release_now,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic                          voice_dead
);

    localparam int TBL_SIZE    = 1 << SINE_TABLE_BITS;
    localparam int ENV_PROD_W  = 2 * ENV_W - 1;
    localparam int MIX_W       = 20;
    localparam int M3_W        = 20;
    localparam int Q_W         = SAMPLE_BITS + 3;
    localparam int Q_SHIFT     = 49 - SAMPLE_BITS;
    localparam int RECIP_SHIFT = Q_W + 5;
    localparam int MUL_A_W     = (PHASE_BITS > ENV_PROD_W)
                                 ? ((PHASE_BITS > Q_W) ? PHASE_BITS : Q_W)
                                 : ((ENV_PROD_W > Q_W) ? ENV_PROD_W : Q_W);
    localparam int MUL_B_W     = (Q_W + 1 > M3_W) ? Q_W + 1 : M3_W;
    localparam int MUL_W       = MUL_A_W + MUL_B_W;
    localparam int SUM_W       = SAMPLE_BITS + 2;

    // Rounding half of 50 * 2^(48 - SAMPLE_BITS), and the reciprocal of 25.
    localparam logic [MUL_W-1:0] Q_ROUND = MUL_W'(64'd25 << (48 - SAMPLE_BITS));
    localparam logic [63:0]      RECIP   = ((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    typedef logic signed [SINE_W-1:0] rom_t [TBL_SIZE];

    // Full-wave sine table, built from quarter-wave symmetry.
    function automatic rom_t build_rom();
        rom_t r;
        int   i;
        for (i = 0; i < TBL_SIZE; i++)
        begin
            if (i <= TBL_SIZE / 4)
                r[i] = quarter_sine(32'(i), SINE_TABLE_BITS);
            else if (i <= TBL_SIZE / 2)
                r[i] = quarter_sine(32'(TBL_SIZE / 2 - i), SINE_TABLE_BITS);
            else if (i <= 3 * TBL_SIZE / 4)
                r[i] = -quarter_sine(32'(i - TBL_SIZE / 2), SINE_TABLE_BITS);
            else
                r[i] = -quarter_sine(32'(TBL_SIZE - i), SINE_TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Square of plus or minus one half, zero where the sine is exactly zero.
    function automatic logic signed [SINE_W-1:0] square_of(
        input logic signed [SINE_W-1:0] s);
        if (s > 0)
            return HALF_Q15;
        else if (s < 0)
            return -HALF_Q15;
        else
            return '0;
    endfunction

    // Add the signed voice to the sample and clamp to the sample range.
    function automatic logic [SAMPLE_BITS-1:0] mix_sat(
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic [SAMPLE_BITS-1:0]        mag,
        input logic                          neg);
        logic signed [SUM_W-1:0] voice;
        logic signed [SUM_W-1:0] total;
        voice = $signed({2'b00, mag});
        if (neg)
            voice = -voice;
        total = SUM_W'(smp) + voice;
        if (total > SAT_HI)
            total = SAT_HI;
        if (total < SAT_LO)
            total = SAT_LO;
        return SAMPLE_BITS'(total);
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] phase_step_reg;
    logic [DET_W-1:0] detune_reg;
    logic [ENV_W-1:0] attack_step_reg;
    logic [ENV_W-1:0] release_step_reg;

    // Voice state.
    logic [PHASE_BITS-1:0] phase_main_reg;
    logic [PHASE_BITS-1:0] phase_upper_reg;
    logic [PHASE_BITS-1:0] phase_lower_reg;
    logic [ENV_W-1:0]      attack_level_reg;
    logic [ENV_W-1:0]      release_level_reg;
    logic                  dying_reg;
    logic                  dead_reg;

    // Sequencer.
    logic [UC_W-1:0] pc_reg;
    logic [UC_W-1:0] pc_next;
    ctrl_t           ctrl;
    logic            go;

    // Datapath.
    logic [SINE_TABLE_BITS-1:0]   rom_addr;
    logic signed [SINE_W-1:0]     rom_q_reg;
    logic signed [SINE_W-1:0]     sine_reg;
    logic signed [SINE_W-1:0]     upper_reg;
    logic signed [SINE_W-1:0]     lower_reg;
    logic signed [SAMPLE_BITS-1:0] in_left_reg;
    logic signed [SAMPLE_BITS-1:0] in_right_reg;
    logic [ENV_PROD_W-1:0]        env_reg;
    logic [M3_W-1:0]              m3_l_reg;
    logic [M3_W-1:0]              m3_r_reg;
    logic                         neg_l_reg;
    logic                         neg_r_reg;
    logic [Q_W-1:0]               q_l_reg;
    logic [Q_W-1:0]               q_r_reg;
    logic [SAMPLE_BITS-1:0]       res_l_reg;
    logic [MUL_A_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]           mul_b;
    logic [MUL_W-1:0]             prod_reg;

    // Output register.
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;
    logic                          voice_dead_reg;

    // Derived values.
    logic [PHASE_BITS-1:0] step_eff;
    logic [PHASE_BITS-1:0] detune_off;
    logic [ENV_W:0]        attack_sum;
    logic [ENV_W-1:0]      attack_next;
    logic [ENV_W-1:0]      release_next;
    logic signed [MIX_W-1:0] sum_l;
    logic signed [MIX_W-1:0] sum_r;
    logic signed [MIX_W-1:0] m_l;
    logic signed [MIX_W-1:0] m_r;
    logic [MIX_W-1:0]      mag_l;
    logic [MIX_W-1:0]      mag_r;
    logic [Q_W-1:0]        q_next;
    logic [SAMPLE_BITS-1:0] v_mag;

    // Control word decode and step advance.
    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        unique case (ctrl.hold)
            HOLD_IN:  go = in_valid;
            HOLD_OUT: go = !out_valid_reg || !out_stall;
            default:  go = 1'b1;
        endcase
    end

    always_comb
    begin
        if (!go)
            pc_next = pc_reg;
        else if (ctrl.jump)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + UC_W'(1);
    end

    assign in_stall = (ctrl.hold != HOLD_IN);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            detune_reg       <= '0;
            attack_step_reg  <= ENV_ONE;
            release_step_reg <= ENV_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                REG_DETUNE:       detune_reg       <= cfg_data[DET_W-1:0];
                REG_ATTACK_STEP:  attack_step_reg  <= cfg_data[ENV_W-1:0];
                REG_RELEASE_STEP: release_step_reg <= cfg_data[ENV_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sine ROM, read one address a cycle.
    always_comb
    begin
        unique case (ctrl.addr_sel)
            ADDR_UPPER: rom_addr = phase_upper_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
            ADDR_LOWER: rom_addr = phase_lower_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
            default:    rom_addr = phase_main_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
        endcase
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_addr];
    end

    // Shared multiplier with registered product.
    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_DETUNE:
            begin
                mul_a = MUL_A_W'(step_eff);
                mul_b = MUL_B_W'(detune_reg);
            end
            MUL_ENV:
            begin
                mul_a = MUL_A_W'(attack_level_reg);
                mul_b = MUL_B_W'(release_level_reg);
            end
            MUL_LEFT:
            begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = MUL_B_W'(m3_l_reg);
            end
            MUL_RIGHT:
            begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = MUL_B_W'(m3_r_reg);
            end
            MUL_RECIP_L:
            begin
                mul_a = MUL_A_W'(q_l_reg);
                mul_b = MUL_B_W'(RECIP);
            end
            MUL_RECIP_R:
            begin
                mul_a = MUL_A_W'(q_r_reg);
                mul_b = MUL_B_W'(RECIP);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    // Phase offset and envelope next values.
    assign step_eff   = phase_step_reg[PHASE_BITS-1:0];
    assign detune_off = PHASE_BITS'(prod_reg >> DET_W);

    assign attack_sum  = {1'b0, attack_level_reg} + {1'b0, attack_step_reg};
    assign attack_next = (attack_sum > {1'b0, ENV_ONE}) ? ENV_ONE : attack_sum[ENV_W-1:0];
    assign release_next = (release_level_reg > release_step_reg)
                          ? release_level_reg - release_step_reg : '0;

    // Oscillator mix: five times (sine plus one square) plus the other square.
    always_comb
    begin
        sum_l = MIX_W'(sine_reg) + MIX_W'(upper_reg);
        sum_r = MIX_W'(sine_reg) + MIX_W'(lower_reg);
        m_l   = (sum_l <<< 2) + sum_l + MIX_W'(lower_reg);
        m_r   = (sum_r <<< 2) + sum_r + MIX_W'(upper_reg);
        mag_l = m_l[MIX_W-1] ? MIX_W'(-m_l) : MIX_W'(m_l);
        mag_r = m_r[MIX_W-1] ? MIX_W'(-m_r) : MIX_W'(m_r);
    end

    // Rounded scaling: first the power-of-two part, then the divide by 25.
    assign q_next = Q_W'((prod_reg + Q_ROUND) >> Q_SHIFT);
    assign v_mag  = SAMPLE_BITS'(prod_reg >> RECIP_SHIFT);

    // Sequencer and voice state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg            <= UC_ACCEPT;
            phase_main_reg    <= '0;
            phase_upper_reg   <= '0;
            phase_lower_reg   <= '0;
            attack_level_reg  <= '0;
            release_level_reg <= ENV_ONE;
            dying_reg         <= 1'b0;
            dead_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;

            if (go && ctrl.ld_in && release_now)
                dying_reg <= 1'b1;

            if (go && ctrl.upd_env)
            begin
                attack_level_reg <= attack_next;
                if (dying_reg)
                begin
                    if (release_level_reg != '0)
                        release_level_reg <= release_next;
                    else
                        dead_reg <= 1'b1;
                end
            end

            if (go && ctrl.upd_phase)
            begin
                phase_main_reg  <= phase_main_reg + step_eff;
                phase_upper_reg <= phase_upper_reg + step_eff + detune_off;
                phase_lower_reg <= phase_lower_reg + step_eff - detune_off;
            end

            // Output valid: set on delivery, cleared on transfer.
            if (go && ctrl.ld_out)
                out_valid_reg <= 1'b1;
            else if (out_stall == 1'b0)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (go && ctrl.ld_in)
        begin
            in_left_reg  <= in_left;
            in_right_reg <= in_right;
        end
        if (ctrl.ld_sine)
            sine_reg <= rom_q_reg;
        if (ctrl.ld_upper)
            upper_reg <= square_of(rom_q_reg);
        if (ctrl.ld_lower)
            lower_reg <= square_of(rom_q_reg);
        if (ctrl.ld_env)
            env_reg <= ENV_PROD_W'(prod_reg);
        if (ctrl.ld_mix)
        begin
            m3_l_reg  <= M3_W'({mag_l, 1'b0}) + M3_W'(mag_l);
            m3_r_reg  <= M3_W'({mag_r, 1'b0}) + M3_W'(mag_r);
            neg_l_reg <= m_l[MIX_W-1];
            neg_r_reg <= m_r[MIX_W-1];
        end
        if (ctrl.ld_q_l)
            q_l_reg <= q_next;
        if (ctrl.ld_q_r)
            q_r_reg <= q_next;
        if (ctrl.ld_res_l)
            res_l_reg <= mix_sat(in_left_reg, v_mag, neg_l_reg);
        if (go && ctrl.ld_out)
        begin
            out_left_reg   <= res_l_reg;
            out_right_reg  <= mix_sat(in_right_reg, v_mag, neg_r_reg);
            voice_dead_reg <= dead_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;
    assign voice_dead = voice_dead_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import dov_pkg::CFG_W;
    import dov_pkg::CFG_IDX_W;
    import dov_pkg::REG_PHASE_STEP;
    import dov_pkg::REG_DETUNE;
    import dov_pkg::REG_ATTACK_STEP;
    import dov_pkg::REG_RELEASE_STEP;

    localparam int               RANDOM_SETTINGS = 9;
    localparam int               TICKS_PER_SETTING = 128;
    localparam int               STALL_LIMIT = 3000;
    localparam int               PRESSURE_CYCLES = 400;
    localparam int               DRAIN_CYCLES = 16;
    localparam int               ENV_FULL = 65536;
    localparam int               HALF_WAVE = 16384;
    localparam longint unsigned  PI_FIX = 64'd3373259426;
    localparam longint unsigned  ONE_FIX = 64'd1 << 30;
    localparam longint unsigned  MIX_DIV = 64'd50 << 24;
    localparam longint           SAMPLE_MAX = 8388607;
    localparam longint           SAMPLE_MIN = -8388608;

    // One stereo tick offered to the voice.
    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               rel;
    } tick_t;

    // One mixed stereo result.
    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               dead;
    } voice_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [23:0]   in_left = '0;
    logic signed [23:0]   in_right = '0;
    logic                 release_now = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [23:0]   out_left;
    logic signed [23:0]   out_right;
    logic                 voice_dead;

    // Voice state as the testbench sees it.
    logic signed [15:0]   sine_rom [1024];
    logic [31:0]          step_cfg;
    logic [15:0]          detune_cfg;
    logic [16:0]          atk_cfg;
    logic [16:0]          rel_cfg;
    logic [31:0]          ph_main;
    logic [31:0]          ph_up;
    logic [31:0]          ph_lo;
    logic [16:0]          atk_lvl;
    logic [16:0]          rel_lvl;
    logic                 dying;
    logic                 dead;

    tick_t                tick_queue [$];
    voice_out_t           expected_mix [$];
    tick_t                held;
    voice_out_t           head;
    bit                   idle_on = 1'b1;
    int                   gap_left = 0;
    int                   stall_run = 0;
    int                   hold_left = 0;
    bit                   long_hold_done = 1'b0;
    int                   queued = 0;
    int                   sent = 0;
    int                   checked = 0;
    int                   errors = 0;
    int                   settings = 0;
    int                   quiet_cycles = 0;

    detuned_oscillator_voice DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_left     (in_left),
        .in_right    (in_right),
        .release_now (release_now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_left    (out_left),
        .out_right   (out_right),
        .voice_dead  (voice_dead)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Quarter-wave sine in Q1.15 from a Q30 Taylor series up to x^11.
    function automatic int quarter_wave(int unsigned q);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned divs [5];
        divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        x  = (64'd2 * PI_FIX * q) >> 10;
        x2 = (x * x) >> 30;
        t  = ONE_FIX;
        for (int k = 0; k < 5; k++)
            t = ONE_FIX - (((x2 * t) >> 30) / divs[k]);
        s = (x * t) >> 30;
        return int'((s * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic int square_of(logic [31:0] ph);
        int s;
        s = sine_rom[ph[31:22]];
        if (s > 0)
            return HALF_WAVE;
        if (s < 0)
            return -HALF_WAVE;
        return 0;
    endfunction

    // Scale the mix by 0.06 and both envelopes, add it to the input, saturate.
    function automatic logic signed [23:0] mix_sample(logic signed [23:0] in_s, int m);
        int              abs_m;
        longint unsigned mag;
        longint unsigned v;
        longint          sum;
        abs_m = (m < 0) ? -m : m;
        mag = longint'(abs_m) * longint'(atk_lvl) * longint'(rel_lvl) * 64'd3;
        v = (mag + MIX_DIV / 2) / MIX_DIV;
        sum = longint'(in_s) + ((m < 0) ? -longint'(v) : longint'(v));
        if (sum > SAMPLE_MAX)
            sum = SAMPLE_MAX;
        if (sum < SAMPLE_MIN)
            sum = SAMPLE_MIN;
        return 24'(sum);
    endfunction

    // Advance the voice by one tick and return the mix it should produce.
    function automatic voice_out_t voice_tick(tick_t t);
        voice_out_t      r;
        longint unsigned off;
        int              s;
        int              up;
        int              lo;
        logic [17:0]     a;
        off = (longint'(step_cfg) * longint'(detune_cfg)) >> 16;
        if (t.rel)
            dying = 1'b1;
        s  = sine_rom[ph_main[31:22]];
        up = square_of(ph_up);
        lo = square_of(ph_lo);
        ph_main = ph_main + step_cfg;
        ph_up   = ph_up + step_cfg + off[31:0];
        ph_lo   = ph_lo + step_cfg - off[31:0];
        a = atk_lvl + atk_cfg;
        atk_lvl = (a > ENV_FULL) ? 17'(ENV_FULL) : a[16:0];
        if (dying)
        begin
            if (rel_lvl != 0)
                rel_lvl = (rel_lvl > rel_cfg) ? rel_lvl - rel_cfg : '0;
            else
                dead = 1'b1;
        end
        r.left  = mix_sample(t.left, 5 * (s + up) + lo);
        r.right = mix_sample(t.right, 5 * (s + lo) + up);
        r.dead  = dead;
        return r;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [23:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 24'(SAMPLE_MAX);
        if (pick == 1)
            return 24'(SAMPLE_MIN);
        if (pick == 2)
            return 24'(int'($urandom_range(0, 2000)) - 1000);
        return 24'($urandom);
    endfunction

    task automatic add_tick(logic signed [23:0] l, logic signed [23:0] r, logic rel);
        tick_t t;
        t.left  = l;
        t.right = r;
        t.rel   = rel;
        tick_queue.push_back(t);
        queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PHASE_STEP:   step_cfg = val;
            REG_DETUNE:       detune_cfg = val[15:0];
            REG_ATTACK_STEP:  atk_cfg = val[16:0];
            REG_RELEASE_STEP: rel_cfg = val[16:0];
            default:          ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] stp, logic [15:0] det,
                                  logic [16:0] atk, logic [16:0] rel);
        write_reg(REG_PHASE_STEP, stp);
        write_reg(REG_DETUNE, CFG_W'(det));
        write_reg(REG_ATTACK_STEP, CFG_W'(atk));
        write_reg(REG_RELEASE_STEP, CFG_W'(rel));
        settings++;
    endtask

    // Wait until every queued tick has come back as a checked result.
    task automatic wait_idle();
        while (tick_queue.size() != 0 || checked < queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sender: offers queued ticks and predicts each one as it transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            in_left     <= '0;
            in_right    <= '0;
            release_now <= 1'b0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_mix.push_back(voice_tick(held));
                sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    held = tick_queue.pop_front();
                    in_left     <= held.left;
                    in_right    <= held.right;
                    release_now <= held.rel;
                    in_valid    <= 1'b1;
                    gap_left = (idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each transferred result and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_mix.size() == 0)
                begin
                    $error("unexpected result: out_left %0d, out_right %0d", out_left,
                           out_right);
                    errors++;
                end
                else
                begin
                    head = expected_mix.pop_front();
                    if (out_left !== head.left)
                    begin
                        $error("out_left: expected %0d, got %0d", head.left, out_left);
                        errors++;
                    end
                    if (out_right !== head.right)
                    begin
                        $error("out_right: expected %0d, got %0d", head.right, out_right);
                        errors++;
                    end
                    if (voice_dead !== head.dead)
                    begin
                        $error("voice_dead: expected %0d, got %0d", head.dead, voice_dead);
                        errors++;
                    end
                    checked++;
                end
            end

            // One long hold-off mid-run lets the block fill up and stall its input.
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && checked >= 300)
            begin
                long_hold_done = 1'b1;
                hold_left = PRESSURE_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 99) < 25)
            begin
                stall_run = idle_len() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transfer", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus and run control.
    initial
    begin
        logic [31:0] stp;
        logic [15:0] det;
        logic [16:0] rel;
        int          pick;

        for (int i = 0; i < 1024; i++)
        begin
            if (i <= 256)
                sine_rom[i] = 16'(quarter_wave(i));
            else if (i <= 512)
                sine_rom[i] = 16'(quarter_wave(512 - i));
            else if (i <= 768)
                sine_rom[i] = 16'(-quarter_wave(i - 512));
            else
                sine_rom[i] = 16'(-quarter_wave(1024 - i));
        end
        step_cfg   = '0;
        detune_cfg = '0;
        atk_cfg    = 17'(ENV_FULL);
        rel_cfg    = 17'(ENV_FULL);
        ph_main    = '0;
        ph_up      = '0;
        ph_lo      = '0;
        atk_lvl    = '0;
        rel_lvl    = 17'(ENV_FULL);
        dying      = 1'b0;
        dead       = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Silent voice: zero step and zero attack, so the input passes through.
        apply_settings(32'h0, 16'h0, 17'h0, 17'h0);
        add_tick(24'(SAMPLE_MAX), 24'(SAMPLE_MAX), 1'b0);
        add_tick(24'(SAMPLE_MIN), 24'(SAMPLE_MIN), 1'b0);
        add_tick(24'sd0, -24'sd1, 1'b0);
        add_tick(-24'sd1, 24'sd0, 1'b0);
        wait_idle();

        // Half-turn step keeps the sine on its zero entries; full detune; slow attack.
        apply_settings(32'h8000_0000, 16'hFFFF, 17'h3000, 17'h0);
        add_tick(24'(SAMPLE_MAX), 24'(SAMPLE_MIN), 1'b0);
        add_tick(24'(SAMPLE_MIN), 24'(SAMPLE_MAX), 1'b0);
        add_tick(24'sd0, 24'sd0, 1'b0);
        add_tick(24'(SAMPLE_MAX), 24'(SAMPLE_MAX), 1'b0);
        add_tick(24'(SAMPLE_MIN), 24'(SAMPLE_MIN), 1'b0);
        add_tick(-24'sd1, -24'sd1, 1'b0);
        wait_idle();

        // Full attack step; release requested while the release step is zero.
        apply_settings(32'h0400_0000, 16'h1000, 17'(ENV_FULL), 17'h0);
        for (int k = 0; k < 10; k++)
            add_tick(rand_sample(), rand_sample(), k == 2);
        wait_idle();

        // Random settings; the release ramps down only in the last few.
        for (int p = 0; p < RANDOM_SETTINGS; p++)
        begin
            pick = $urandom_range(0, 5);
            if (p == 0)
                stp = 32'hFFFF_FFFF;
            else if (pick == 0)
                stp = 32'h8000_0000 + $urandom_range(0, 255);
            else if (pick <= 2)
                stp = $urandom_range(0, 32'h0400_0000);
            else
                stp = $urandom;
            if (p == 3)
                det = 16'h0;
            else if (p == 4)
                det = 16'hFFFF;
            else
                det = 16'($urandom);
            if (p < 6)
                rel = 17'h0;
            else if (p == 6)
                rel = 17'($urandom_range(200, 700));
            else if (p == 7)
                rel = 17'(ENV_FULL);
            else
                rel = 17'($urandom_range(0, ENV_FULL));
            apply_settings(stp, det, 17'($urandom_range(0, ENV_FULL)), rel);
            idle_on = (p != 2);
            for (int k = 0; k < TICKS_PER_SETTING; k++)
                add_tick(rand_sample(), rand_sample(),
                         (p < 6) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0));
            wait_idle();
        end
        idle_on = 1'b1;

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d stereo ticks under %0d register settings, %0d results checked.",
                 sent, settings, checked);
        $display("Attack ramp, detuned squares, release ramp to zero and the dead flag (%0d).",
                 dead);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
